/* hdl/sud_pkg.sv */
// sud_pkg: shared types and field widths for the set union / dedup block.
// No dependencies.
package sud_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 7;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [COUNT_OUT_W-1:0]    count_out_t;

endpackage

/* hdl/sud_stream_if.sv */
// sud_in_if / sud_out_if: valid/ready channels of the set union block.
// Depends on sud_pkg for payload types.
interface sud_in_if;
    logic            valid;
    logic            ready;
    sud_pkg::value_t value;
    logic            last_of_set;

    modport source (output valid, output value, output last_of_set, input ready);
    modport sink   (input valid, input value, input last_of_set, output ready);
endinterface

interface sud_out_if;
    logic                valid;
    logic                ready;
    sud_pkg::value_t     value_out;
    logic                keep;
    sud_pkg::count_out_t distinct_count;
    logic                overflow;
    logic                last_out;

    modport source (output valid, output value_out, output keep, output distinct_count,
                    output overflow, output last_out, input ready);
    modport sink   (input valid, input value_out, input keep, input distinct_count,
                    input overflow, input last_out, output ready);
endinterface

/* hdl/sud_ram.sv */
// sud_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sud_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/set_union_dedup.sv */
// set_union_dedup: streaming set union with duplicate removal.
// Depends on sud_pkg, sud_in_if / sud_out_if and sud_ram.
//
//  channel   direction  payload
//  in_ch     sink       value, last_of_set
//  out_ch    source     value_out, keep, distinct_count, overflow, last_out
//
// A transaction runs IDLE, SCAN over the n distinct values now stored (up to
// MAX_ENTRIES; skipped if n is 0), then FINISH. The scan reads the store RAM one
// entry per cycle and stops early on a hit. in_ch.ready is high only while idle.
// Reset clears the count and control; the store RAM needs no clearing pass,
// only entries below the count are ever compared.
// A stalled out_ch holds the finished result; the next input transaction is
// taken as soon as the result sits in the output register.
module set_union_dedup #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    sud_in_if.sink     in_ch,
    sud_out_if.source  out_ch
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  hit_reg, hit_next;
    sud_pkg::value_t       val_reg, val_next;
    logic                  last_reg, last_next;

    logic                  out_valid_reg, out_valid_next;
    sud_pkg::value_t       out_value_reg, out_value_next;
    logic                  out_keep_reg, out_keep_next;
    sud_pkg::count_out_t   out_count_reg, out_count_next;
    logic                  out_ovf_reg, out_ovf_next;
    logic                  out_last_reg, out_last_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_raddr;
    sud_pkg::value_t       ram_rdata;
    logic                  new_entry;
    logic [CNT_W-1:0]      cnt_upd;
    logic [CNT_W+sud_pkg::COUNT_OUT_W-1:0] cnt_ext;

    sud_ram #(
        .WIDTH (sud_pkg::VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (val_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read address runs one ahead of idx_reg: entry idx_reg is on rdata in SCAN.
    assign ram_raddr = (state_reg == ST_IDLE) ? '0 : idx_reg + AW'(1);

    assign new_entry = !hit_reg && (cnt_reg < MAX_ENTRIES);
    assign cnt_upd   = cnt_reg + CNT_W'(new_entry);
    assign cnt_ext   = (CNT_W + sud_pkg::COUNT_OUT_W)'(cnt_upd);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_value_next = out_value_reg;
        out_keep_next  = out_keep_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    val_next   = in_ch.value;
                    last_next  = in_ch.last_of_set;
                    hit_next   = 1'b0;
                    idx_next   = '0;
                    state_next = (cnt_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ram_rdata == val_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (CNT_W'(idx_reg) + CNT_W'(1) == cnt_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_FINISH:
            begin
                // commit only when the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    ram_we         = new_entry;
                    out_valid_next = 1'b1;
                    out_value_next = val_reg;
                    out_keep_next  = new_entry;
                    out_ovf_next   = !hit_reg && !new_entry;
                    out_count_next = cnt_ext[sud_pkg::COUNT_OUT_W-1:0];
                    out_last_next  = last_reg;
                    cnt_next       = last_reg ? '0 : cnt_upd;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        val_reg       <= val_next;
        last_reg      <= last_next;
        out_value_reg <= out_value_next;
        out_keep_reg  <= out_keep_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign in_ch.ready           = (state_reg == ST_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.value_out      = out_value_reg;
    assign out_ch.keep           = out_keep_reg;
    assign out_ch.distinct_count = out_count_reg;
    assign out_ch.overflow       = out_ovf_reg;
    assign out_ch.last_out       = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_ENTRIES)
        else $error("stored count above capacity");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (cnt_reg < MAX_ENTRIES) && (state_reg == ST_FINISH))
        else $error("store write without room or outside commit");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a commit");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_keep_reg && out_ovf_reg))
        else $error("keep and overflow both set");

endmodule
